### rtl/core/wfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfp_pkg;

	localparam int unsigned MAX_BUFFER_BYTES_DEF = 4194304;
	localparam int unsigned QUEUE_DEPTH_DEF      = 4;

	localparam int unsigned BUF_SIZE_W = 23;
	localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 23'd65536;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_FRAGMENTED = 2'd1;
	localparam logic [1:0] ERR_OPCODE     = 2'd2;
	localparam logic [1:0] ERR_TOO_BIG    = 2'd3;

	// Supported opcodes.
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// Seven-bit length codes that announce an extended length.
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic [1:0]            kind;
		logic [3:0]            opcode;
		logic                  is_masked;
		logic [BUF_SIZE_W-1:0] frame_length;
		logic [7:0]            payload_byte;
		logic                  last_of_frame;
		logic [1:0]            error_code;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/wfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wfp_front #(
	parameter int unsigned MAX_BUFFER_BYTES = wfp_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [wfp_pkg::BUF_SIZE_W-1:0] cfg_data,
	input  wire logic                           byte_valid,
	input  wire logic [7:0]                     rx_byte,
	output wire logic                           res_valid,
	output wfp_pkg::result_t                    res
);

	localparam int unsigned LIM_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int unsigned CMP_W = ((LIM_W > wfp_pkg::BUF_SIZE_W) ?
		LIM_W : wfp_pkg::BUF_SIZE_W) + 1;
	localparam logic [CMP_W-1:0] LIMIT_MAX = CMP_W'(MAX_BUFFER_BYTES);

	localparam logic [2:0] PH_HDR0  = 3'd0;
	localparam logic [2:0] PH_HDR1  = 3'd1;
	localparam logic [2:0] PH_EXT16 = 3'd2;
	localparam logic [2:0] PH_EXT64 = 3'd3;
	localparam logic [2:0] PH_KEY   = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;

	logic [wfp_pkg::BUF_SIZE_W-1:0] buf_size_q;
	logic [2:0]                     phase_q, phase_d;
	logic [3:0]                     cnt_q, cnt_d;
	logic [3:0]                     opcode_q, opcode_d;
	logic [LIM_W-1:0]               acc_q, acc_d;
	logic                           acc_high_q, acc_high_d;
	logic [31:0]                    key_q, key_d;
	logic                           mask_q, mask_d;
	logic [wfp_pkg::BUF_SIZE_W-1:0] remain_q, remain_d;
	logic                           halt_q, halt_d;

	logic                           valid_c;
	wfp_pkg::result_t               res_c;

	// Length check inputs, shared by the seven-bit and extended cases.
	logic [LIM_W-1:0]               acc_cand;
	logic                           high_cand;
	logic                           mask_cand;
	logic [3:0]                     hdr_len;
	logic [CMP_W-1:0]               limit;
	logic [CMP_W-1:0]               total;
	logic                           too_big;
	logic [CMP_W-1:0]               acc_ext;
	logic                           do_len;
	logic                           do_hdr;
	logic [wfp_pkg::BUF_SIZE_W-1:0] hdr_length;
	logic                           hdr_mask;
	logic                           op_ok;

	always_comb begin
		limit = (CMP_W'(buf_size_q) < LIMIT_MAX) ? CMP_W'(buf_size_q) : LIMIT_MAX;
		if (phase_q == PH_HDR1) begin
			acc_cand  = LIM_W'(rx_byte[6:0]);
			high_cand = 1'b0;
			mask_cand = rx_byte[7];
			hdr_len   = 4'd2;
		end else begin
			acc_cand  = {acc_q[LIM_W-9:0], rx_byte};
			high_cand = acc_high_q || (acc_q[LIM_W-1 -: 8] != 8'd0);
			mask_cand = mask_q;
			hdr_len   = (phase_q == PH_EXT16) ? 4'd4 : 4'd10;
		end
		acc_ext = CMP_W'(acc_cand);
		total   = acc_ext + CMP_W'(hdr_len) + (mask_cand ? CMP_W'(4) : CMP_W'(0));
		too_big = high_cand || (total > limit);
		op_ok   = (rx_byte[3:0] == wfp_pkg::OP_TEXT)  || (rx_byte[3:0] == wfp_pkg::OP_BINARY) ||
		          (rx_byte[3:0] == wfp_pkg::OP_CLOSE) || (rx_byte[3:0] == wfp_pkg::OP_PING) ||
		          (rx_byte[3:0] == wfp_pkg::OP_PONG);
	end

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		opcode_d   = opcode_q;
		acc_d      = acc_q;
		acc_high_d = acc_high_q;
		key_d      = key_q;
		mask_d     = mask_q;
		remain_d   = remain_q;
		halt_d     = halt_q;
		valid_c    = 1'b0;
		res_c      = '0;
		res_c.opcode = opcode_q;
		do_len     = 1'b0;
		do_hdr     = 1'b0;
		hdr_length = remain_q;
		hdr_mask   = mask_q;

		if (byte_valid && !halt_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					opcode_d     = rx_byte[3:0];
					res_c.opcode = rx_byte[3:0];
					if (!rx_byte[7]) begin
						halt_d           = 1'b1;
						valid_c          = 1'b1;
						res_c.kind       = wfp_pkg::KIND_ERROR;
						res_c.error_code = wfp_pkg::ERR_FRAGMENTED;
					end else if (!op_ok) begin
						halt_d           = 1'b1;
						valid_c          = 1'b1;
						res_c.kind       = wfp_pkg::KIND_ERROR;
						res_c.error_code = wfp_pkg::ERR_OPCODE;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					mask_d     = rx_byte[7];
					key_d      = '0;
					acc_d      = '0;
					acc_high_d = 1'b0;
					if (rx_byte[6:0] == wfp_pkg::LEN_EXT16) begin
						phase_d = PH_EXT16;
						cnt_d   = 4'd2;
					end else if (rx_byte[6:0] == wfp_pkg::LEN_EXT64) begin
						phase_d = PH_EXT64;
						cnt_d   = 4'd8;
					end else begin
						do_len = 1'b1;
					end
				end
				PH_EXT16, PH_EXT64: begin
					acc_d      = acc_cand;
					acc_high_d = high_cand;
					cnt_d      = cnt_q - 4'd1;
					do_len     = (cnt_q == 4'd1);
				end
				PH_KEY: begin
					key_d = {key_q[23:0], rx_byte};
					cnt_d = cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						do_hdr = 1'b1;
					end
				end
				PH_DATA: begin
					// The key rotates so that its top byte is always the one in use.
					key_d              = {key_q[23:0], key_q[31:24]};
					remain_d           = remain_q - 1'b1;
					valid_c            = 1'b1;
					res_c.kind         = wfp_pkg::KIND_PAYLOAD;
					res_c.is_masked    = mask_q;
					res_c.payload_byte = rx_byte ^ key_q[31:24];
					if (remain_q == wfp_pkg::BUF_SIZE_W'(1)) begin
						res_c.last_of_frame = 1'b1;
						phase_d             = PH_HDR0;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			if (do_len) begin
				if (too_big) begin
					halt_d           = 1'b1;
					valid_c          = 1'b1;
					res_c.kind       = wfp_pkg::KIND_ERROR;
					res_c.error_code = wfp_pkg::ERR_TOO_BIG;
				end else begin
					remain_d   = acc_ext[wfp_pkg::BUF_SIZE_W-1:0];
					hdr_length = acc_ext[wfp_pkg::BUF_SIZE_W-1:0];
					hdr_mask   = mask_cand;
					if (mask_cand) begin
						phase_d = PH_KEY;
						cnt_d   = 4'd4;
					end else begin
						do_hdr = 1'b1;
					end
				end
			end

			if (do_hdr) begin
				valid_c             = 1'b1;
				res_c.kind          = wfp_pkg::KIND_HEADER;
				res_c.is_masked     = hdr_mask;
				res_c.frame_length  = hdr_length;
				res_c.last_of_frame = (hdr_length == '0);
				phase_d             = (hdr_length == '0) ? PH_HDR0 : PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= wfp_pkg::BUF_SIZE_RESET;
			phase_q    <= PH_HDR0;
			cnt_q      <= '0;
			opcode_q   <= '0;
			acc_q      <= '0;
			acc_high_q <= 1'b0;
			key_q      <= '0;
			mask_q     <= 1'b0;
			remain_q   <= '0;
			halt_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				buf_size_q <= cfg_data;
			end
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			opcode_q   <= opcode_d;
			acc_q      <= acc_d;
			acc_high_q <= acc_high_d;
			key_q      <= key_d;
			mask_q     <= mask_d;
			remain_q   <= remain_d;
			halt_q     <= halt_d;
		end
	end

	assign res_valid = valid_c;
	assign res       = res_c;

	// Once halted, the parser never produces another transaction.
	assert property (@(posedge clk) disable iff (!arst_n) halt_q |-> !valid_c)
		else $error("result produced after error halt");

	// The payload phase always has at least one byte left.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remain_q != '0))
		else $error("payload phase with no bytes remaining");

	// An error result always sets the halt flag for the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c && res_c.kind == wfp_pkg::KIND_ERROR) |=> halt_q)
		else $error("error result without halt");

endmodule

`default_nettype wire

### rtl/core/wfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wfp_queue #(
	parameter int unsigned DEPTH = wfp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire wfp_pkg::result_t wr_data,
	output wire logic             full,
	input  wire logic             rd_en,
	output wire logic             empty,
	output wfp_pkg::result_t      rd_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	wfp_pkg::result_t mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not drop after a read");

	assert property (@(posedge clk) disable iff (!arst_n) !(full && empty))
		else $error("queue reports full and empty together");

endmodule

`default_nettype wire

### rtl/core/websocket_frame_parser_core.sv
// WebSocket frame deframer.
// Input channel: rx_byte with push/full. A byte is taken at a rising edge with
// push high and full low. Output channel: empty/pop. While empty is low the
// oldest result sits on kind, opcode, is_masked, frame_length, payload_byte,
// last_of_frame and error_code; it is taken at an edge with pop high.
// Configuration: buffer_size is written at any edge with buffer_size_we high.
// Write it only while no bytes are in flight.
// Throughput is one byte per cycle while full is low: the header parser
// updates its state once per byte. A result is written into the queue at the
// edge that takes its byte. Header bytes that complete nothing give no result.
// A result queue of QUEUE_DEPTH entries sits between the parser and the output;
// if the receiver stops popping, the parser keeps taking bytes until the queue
// fills, and full then holds the sender off.
// Reset clears the parser, the queue and the error halt, and sets buffer_size
// to 65536. After an error result the block takes bytes but discards them.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_parser_core #(
	parameter int unsigned MAX_BUFFER_BYTES = wfp_pkg::MAX_BUFFER_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH      = wfp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           buffer_size_we,
	input  wire logic [wfp_pkg::BUF_SIZE_W-1:0] buffer_size,
	input  wire logic                           push,
	output wire logic                           full,
	input  wire logic [7:0]                     rx_byte,
	output wire logic                           empty,
	input  wire logic                           pop,
	output wire logic [1:0]                     kind,
	output wire logic [3:0]                     opcode,
	output wire logic                           is_masked,
	output wire logic [wfp_pkg::BUF_SIZE_W-1:0] frame_length,
	output wire logic [7:0]                     payload_byte,
	output wire logic                           last_of_frame,
	output wire logic [1:0]                     error_code
);

	logic             byte_accept;
	logic             res_valid;
	wfp_pkg::result_t res;
	wfp_pkg::result_t head;

	assign byte_accept = push && !full;

	wfp_front #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (buffer_size_we),
		.cfg_data  (buffer_size),
		.byte_valid(byte_accept),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(res),
		.full   (full),
		.rd_en  (pop),
		.empty  (empty),
		.rd_data(head)
	);

	assign kind          = head.kind;
	assign opcode        = head.opcode;
	assign is_masked     = head.is_masked;
	assign frame_length  = head.frame_length;
	assign payload_byte  = head.payload_byte;
	assign last_of_frame = head.last_of_frame;
	assign error_code    = head.error_code;

endmodule

`default_nettype wire
